// ===== rtl/pmst_pkg.sv =====
// ---------------------------------------------------------------------------
// pmst_pkg
// Shared constants, payload types and controller/datapath interface structs
// for the minimum spanning tree block.
// ---------------------------------------------------------------------------
`default_nettype none

package pmst_pkg;

	localparam int MAX_NODES = 16;
	localparam int VTX_W     = $clog2(MAX_NODES);
	localparam int CNT_W     = $clog2(MAX_NODES + 1);
	localparam int WGT_W     = 16;
	localparam int NC_W      = 5;
	localparam int ST_W      = 2;
	localparam int MAT_DEPTH = MAX_NODES * MAX_NODES;
	localparam int MAT_AW    = 2 * VTX_W;
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;

	// opcodes of an input transaction
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_RUN   = 1'b1;

	// result status codes
	localparam logic [ST_W-1:0] ST_EDGE    = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY   = 2'd1;
	localparam logic [ST_W-1:0] ST_DISCONN = 2'd2;

	// register index (paddr[2]) of node_count
	localparam logic REG_NODE_COUNT = 1'b0;

	typedef struct packed {
		logic             opcode;
		logic [VTX_W-1:0] row_index;
		logic [VTX_W-1:0] col_index;
		logic [WGT_W-1:0] edge_weight_in;
	} in_item_t;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [VTX_W-1:0] from_vertex;
		logic [VTX_W-1:0] to_vertex;
		logic [WGT_W-1:0] edge_weight_out;
		logic             last;
	} out_item_t;

	typedef struct packed {
		logic wr;     // store one matrix entry
		logic start;  // begin a run
		logic step;   // issue one matrix read of the scan
		logic emit;   // load the output register with a result
	} ctrl_cmd_t;

	typedef struct packed {
		logic single;     // configured count gives one vertex
		logic scan_last;  // current read address is the last of the round
		logic out_free;   // output register can take a result this cycle
		logic last_res;   // the pending result closes the run
	} ctrl_sts_t;

endpackage

`default_nettype wire

// ===== rtl/prim_minimum_spanning_tree.sv =====
// A write transaction (opcode 0) stores one symmetric matrix weight, and
// writes may arrive back to back. A run transaction (opcode 1) grows a
// minimum spanning tree from vertex 0 over node_count vertices and holds
// in_stall high until its last result is loaded into the output register.
// Each round reads the n x n matrix through the single read port of the
// weight RAM, one entry per cycle, then passes a wait state for the compare
// and an emit state for the result load, which waits while out_stall holds
// a result back. Results carry last=1 on the final one of a run; a single
// vertex gives one empty-tree result and an unreachable vertex ends the run
// with a disconnected result. Unwritten matrix entries read as zero from
// reset on, with no clearing pass.
// ---------------------------------------------------------------------------
// prim_minimum_spanning_tree
// Top level: APB register port, sequencer and datapath.
// ---------------------------------------------------------------------------
`default_nettype none

module prim_minimum_spanning_tree (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [pmst_pkg::APB_AW-1:0]   paddr,
	input  wire logic [pmst_pkg::APB_DW-1:0]   pwdata,
	output logic      [pmst_pkg::APB_DW-1:0]   prdata,
	output logic                               pready,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire pmst_pkg::in_item_t            in_data,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output pmst_pkg::out_item_t                out_data
);
	import pmst_pkg::*;

	logic [NC_W-1:0] node_count_q;
	logic            reg_sel;
	ctrl_cmd_t       cmd;
	ctrl_sts_t       sts;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_NODE_COUNT) && (paddr[1:0] == 2'b00);
	assign prdata  = reg_sel ? APB_DW'(node_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NC_W'(1);
		end else if (psel && penable && pwrite && pready &&
			(paddr[2] == REG_NODE_COUNT)) begin
			node_count_q <= pwdata[NC_W-1:0];
		end
	end

	pmst_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_op   (in_data.opcode),
		.in_stall(in_stall),
		.cmd     (cmd),
		.sts     (sts)
	);

	pmst_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.node_count(node_count_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// ===== rtl/pmst_ram.sv =====
// ---------------------------------------------------------------------------
// pmst_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module pmst_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/pmst_ctrl.sv =====
// ---------------------------------------------------------------------------
// pmst_ctrl
// Sequencer: takes input transactions, steps the matrix scan of each round
// and hands results to the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module pmst_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_op,
	output logic                     in_stall,
	output pmst_pkg::ctrl_cmd_t      cmd,
	input  wire pmst_pkg::ctrl_sts_t sts
);
	import pmst_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_WAIT = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   fire;

	assign in_stall = (state_q != S_IDLE);
	assign fire     = in_valid && !in_stall;

	always_comb begin
		cmd       = '0;
		cmd.wr    = fire && (in_op == OP_WRITE);
		cmd.start = fire && (in_op == OP_RUN);
		cmd.step  = (state_q == S_SCAN);
		cmd.emit  = (state_q == S_EMIT) && sts.out_free;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.start) begin
					state_d = sts.single ? S_EMIT : S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.scan_last) begin
					state_d = S_WAIT;
				end
			end
			// let the last read of the round reach the compare
			S_WAIT: state_d = S_EMIT;
			S_EMIT: begin
				if (sts.out_free) begin
					state_d = sts.last_res ? S_IDLE : S_SCAN;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result loaded while output register still occupied");

	a_last_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && sts.last_res |=> state_q == S_IDLE && !in_stall)
		else $error("run did not end after its final result");

endmodule

`default_nettype wire

// ===== rtl/pmst_dp.sv =====
// ---------------------------------------------------------------------------
// pmst_dp
// Datapath: weight matrix store, known-vertex set, scan address counters,
// minimum-edge compare and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module pmst_dp (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire pmst_pkg::ctrl_cmd_t              cmd,
	output pmst_pkg::ctrl_sts_t                   sts,
	input  wire pmst_pkg::in_item_t               in_data,
	input  wire logic [pmst_pkg::NC_W-1:0]        node_count,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output pmst_pkg::out_item_t                   out_data
);
	import pmst_pkg::*;

	logic [CNT_W-1:0]     n_eff, n_q, n_m1, added_q;
	logic [MAX_NODES-1:0] known_q;
	logic [VTX_W-1:0]     r_q, c_q;
	logic [MAT_DEPTH-1:0] vld_q;
	logic [MAT_AW-1:0]    raddr, waddr;
	logic [WGT_W-1:0]     ram_rdata, rd_w;

	logic                 rd_v_s1, vld_s1;
	logic [VTX_W-1:0]     r_s1, c_s1;

	logic                 found_q;
	logic [WGT_W-1:0]     best_w_q;
	logic [VTX_W-1:0]     best_r_q, best_c_q;

	logic                 out_valid_q;
	out_item_t            out_q;
	logic                 cand, res_last, edge_res;

	// clamp the configured count into 1..MAX_NODES
	always_comb begin
		if (node_count == '0) begin
			n_eff = CNT_W'(1);
		end else if (int'(node_count) > MAX_NODES) begin
			n_eff = CNT_W'(MAX_NODES);
		end else begin
			n_eff = CNT_W'(node_count);
		end
	end

	assign n_m1 = n_q - CNT_W'(1);

	// the matrix is symmetric: keep one triangle, addressed {larger, smaller}
	assign raddr = (r_q > c_q) ? {r_q, c_q} : {c_q, r_q};
	assign waddr = (in_data.row_index > in_data.col_index) ?
		{in_data.row_index, in_data.col_index} :
		{in_data.col_index, in_data.row_index};

	pmst_ram #(
		.WIDTH(WGT_W),
		.DEPTH(MAT_DEPTH)
	) u_matrix (
		.clk  (clk),
		.we   (cmd.wr),
		.waddr(waddr),
		.wdata(in_data.edge_weight_in),
		.re   (cmd.step),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	// an entry never written since reset reads as no edge
	assign rd_w = vld_s1 ? ram_rdata : '0;

	assign cand = rd_v_s1 && known_q[r_s1] && !known_q[c_s1] && (rd_w != '0) &&
		(!found_q || (rd_w < best_w_q));

	assign edge_res = (n_q != CNT_W'(1)) && found_q;
	assign res_last = !edge_res || (added_q == n_m1);

	always_comb begin
		sts           = '0;
		sts.single    = (n_eff == CNT_W'(1));
		sts.scan_last = (CNT_W'(r_q) == n_m1) && (CNT_W'(c_q) == n_m1);
		sts.out_free  = !out_valid_q || !out_stall;
		sts.last_res  = res_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q         <= CNT_W'(1);
			known_q     <= '0;
			added_q     <= '0;
			r_q         <= '0;
			c_q         <= '0;
			vld_q       <= '0;
			rd_v_s1     <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= cmd.step;
			if (cmd.wr) begin
				vld_q[waddr] <= 1'b1;
			end
			if (cmd.start) begin
				n_q     <= n_eff;
				known_q <= MAX_NODES'(1);
				added_q <= CNT_W'(1);
				found_q <= 1'b0;
				r_q     <= '0;
				c_q     <= '0;
			end else if (cmd.step) begin
				if (CNT_W'(c_q) == n_m1) begin
					c_q <= '0;
					r_q <= r_q + VTX_W'(1);
				end else begin
					c_q <= c_q + VTX_W'(1);
				end
			end
			if (cand) begin
				found_q <= 1'b1;
			end
			if (cmd.emit) begin
				found_q <= 1'b0;
				r_q     <= '0;
				c_q     <= '0;
				if (edge_res) begin
					known_q[best_c_q] <= 1'b1;
					added_q           <= added_q + CNT_W'(1);
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		r_s1   <= r_q;
		c_s1   <= c_q;
		vld_s1 <= vld_q[raddr];
		if (cand) begin
			best_w_q <= rd_w;
			best_r_q <= r_s1;
			best_c_q <= c_s1;
		end
		if (cmd.emit) begin
			out_q.last <= res_last;
			if (edge_res) begin
				out_q.status          <= ST_EDGE;
				out_q.from_vertex     <= best_r_q;
				out_q.to_vertex       <= best_c_q;
				out_q.edge_weight_out <= best_w_q;
			end else begin
				out_q.status          <= (n_q == CNT_W'(1)) ? ST_EMPTY : ST_DISCONN;
				out_q.from_vertex     <= '0;
				out_q.to_vertex       <= '0;
				out_q.edge_weight_out <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_new_vertex_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && edge_res |-> !known_q[best_c_q] && known_q[best_r_q])
		else $error("chosen edge does not leave the known set");

	a_known_grows_by_one: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && edge_res |=>
			$countones(known_q) == $past($countones(known_q)) + 1)
		else $error("known set did not grow by exactly one vertex");

endmodule

`default_nettype wire

// ===== tb/prim_minimum_spanning_tree_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// prim_minimum_spanning_tree_tb
// Self-checking bench for the spanning tree block. Matrix writes and runs go
// in through the input channel, node_count is set over APB between phases,
// and every tree edge, empty-tree and disconnected result is checked against
// a Prim search kept on a private copy of the matrix.
// ---------------------------------------------------------------------------

module prim_minimum_spanning_tree_tb;

	import pmst_pkg::*;

	localparam int HALF_PERIOD    = 6;
	localparam int STALL_LIMIT    = 20000;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 8;
	localparam int TAIL_CYCLES    = 200;
	localparam int PHASE_ITEMS    = 12;
	localparam logic [APB_AW-1:0] NODE_COUNT_ADDR = {REG_NODE_COUNT, 2'b00};

	class mst_scoreboard;
		logic [WGT_W-1:0] weights [MAX_NODES][MAX_NODES];
		logic [NC_W-1:0]  node_cfg;
		out_item_t        pending_q[$];
		int errors, accepted, runs, empties, disconnects, edges;

		function new();
			foreach (weights[r, c])
				weights[r][c] = '0;
			node_cfg = NC_W'(1);
		endfunction

		// zero reads as one vertex, anything above the matrix saturates
		function int active_nodes();
			if (node_cfg < 1)
				return 1;
			if (node_cfg > MAX_NODES)
				return MAX_NODES;
			return int'(node_cfg);
		endfunction

		function int pending();
			return pending_q.size();
		endfunction

		function void queue_result(out_item_t res);
			pending_q = {pending_q, res};
		endfunction

		function string fmt_res(out_item_t res);
			return $sformatf("st=%0d %0d->%0d w=%0d last=%0b", res.status,
				res.from_vertex, res.to_vertex, res.edge_weight_out, res.last);
		endfunction

		function void note_input(in_item_t it);
			int n, added, r, c, best_r, best_c;
			logic [WGT_W-1:0]     best_w;
			logic [MAX_NODES-1:0] known;
			bit found;
			out_item_t res;
			accepted++;
			if (it.opcode == OP_WRITE) begin
				weights[it.row_index][it.col_index] = it.edge_weight_in;
				weights[it.col_index][it.row_index] = it.edge_weight_in;
				return;
			end
			runs++;
			n = active_nodes();
			known = MAX_NODES'(1);
			if (n == 1) begin
				res = '0;
				res.status = ST_EMPTY;
				res.last = 1'b1;
				queue_result(res);
				empties++;
				return;
			end
			for (added = 1; added < n; added++) begin
				found = 0;
				best_r = 0;
				best_c = 0;
				best_w = '0;
				for (r = 0; r < n; r++) begin
					if (!known[r])
						continue;
					for (c = 0; c < n; c++) begin
						if (known[c] || weights[r][c] == 0)
							continue;
						// strict compare keeps the lowest row, then column, on ties
						if (!found || weights[r][c] < best_w) begin
							found = 1;
							best_w = weights[r][c];
							best_r = r;
							best_c = c;
						end
					end
				end
				res = '0;
				if (!found) begin
					res.status = ST_DISCONN;
					res.last = 1'b1;
					queue_result(res);
					disconnects++;
					return;
				end
				known[best_c] = 1'b1;
				res.status = ST_EDGE;
				res.from_vertex = VTX_W'(best_r);
				res.to_vertex = VTX_W'(best_c);
				res.edge_weight_out = best_w;
				res.last = (added == n - 1);
				queue_result(res);
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			string bad;
			if (pending_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %s", $time, fmt_res(got));
				return;
			end
			want = pending_q.pop_front();
			bad = "";
			if (got.status !== want.status)
				bad = {bad, " status"};
			if (got.from_vertex !== want.from_vertex)
				bad = {bad, " from_vertex"};
			if (got.to_vertex !== want.to_vertex)
				bad = {bad, " to_vertex"};
			if (got.edge_weight_out !== want.edge_weight_out)
				bad = {bad, " edge_weight_out"};
			if (got.last !== want.last)
				bad = {bad, " last"};
			if (bad != "") begin
				errors++;
				$display("%0t: mismatch in%s: expected %s, got %s",
					$time, bad, fmt_res(want), fmt_res(got));
			end
			if (want.status == ST_EDGE)
				edges++;
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_stall;
	in_item_t          in_data = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	out_item_t         out_data;

	mst_scoreboard sb;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_req = 0;
	int hold_done = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	prim_minimum_spanning_tree dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// result side: random stall, or a long hold when the sequence asks for one
	always @(negedge clk) begin
		if (hold_req != hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = hold_req;
		end
		if (hold_left > 0) begin
			out_stall = 1'b1;
			hold_left--;
		end else
			out_stall = ($urandom_range(0, 99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if (out_valid === 1'b1 && !out_stall)
			sb.check_result(out_data);
	end

	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) || psel)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("FAIL prim_minimum_spanning_tree");
			$finish;
		end
	end

	function automatic in_item_t mk_item(logic op, int r, int c, int w);
		in_item_t it;
		it.opcode = op;
		it.row_index = VTX_W'(r);
		it.col_index = VTX_W'(c);
		it.edge_weight_in = WGT_W'(w);
		return it;
	endfunction

	function automatic int rand_weight();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			return 0;
		if (pick < 40)
			return $urandom_range(1, 4);
		if (pick < 90)
			return $urandom_range(1, 65535);
		return 16'hFFFF;
	endfunction

	// all tasks start and end just after a falling edge
	task automatic send_batch(input in_item_t items[$]);
		foreach (items[i]) begin
			while ($urandom_range(0, 99) < send_idle_pct) begin
				in_valid = 1'b0;
				@(negedge clk);
			end
			in_valid = 1'b1;
			in_data = items[i];
			do @(posedge clk); while (in_stall);
			sb.note_input(items[i]);
			@(negedge clk);
		end
		in_valid = 1'b0;
	endtask

	task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
			input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = wr;
		paddr = addr;
		pwdata = wdata;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic check_node_count();
		logic [APB_DW-1:0] rd;
		apb_access(1'b0, NODE_COUNT_ADDR, '0, rd);
		if (rd[NC_W-1:0] !== sb.node_cfg) begin
			sb.errors++;
			$display("%0t: node_count readback expected %0d, got %0d", $time,
				sb.node_cfg, rd[NC_W-1:0]);
		end
	endtask

	task automatic set_node_count(input logic [NC_W-1:0] val);
		logic [APB_DW-1:0] rd;
		apb_access(1'b1, NODE_COUNT_ADDR, APB_DW'(val), rd);
		sb.node_cfg = val;
		check_node_count();
	endtask

	// hold until the last result is out and the block has settled
	task automatic drain();
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// mostly a spanning skeleton plus extra edges, sometimes a sparse graph
	task automatic build_scenario(output in_item_t items[$]);
		int n, v, u, extra, r, c;
		n = sb.active_nodes();
		items = {};
		if ($urandom_range(0, 99) < 60) begin
			for (v = 1; v < n; v++) begin
				u = $urandom_range(0, v - 1);
				if ($urandom_range(0, 1))
					items = {items, mk_item(OP_WRITE, v, u, rand_weight())};
				else
					items = {items, mk_item(OP_WRITE, u, v, rand_weight())};
			end
		end
		extra = $urandom_range(0, n);
		repeat (extra) begin
			r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, n - 1);
			c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, n - 1);
			items = {items, mk_item(OP_WRITE, r, c, rand_weight())};
		end
		items = {items, mk_item(OP_RUN, $urandom_range(0, 15), $urandom_range(0, 15),
			$urandom_range(0, 65535))};
	endtask

	initial begin
		in_item_t q[$];
		logic [NC_W-1:0] phase_cfg [6];
		int phase, sent;
		sb = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 9;
		recv_idle_pct = 81;
		check_node_count();

		// one vertex at reset value, then zero vertices with all field bits set
		q = {mk_item(OP_RUN, 0, 0, 0)};
		send_batch(q);
		drain();
		set_node_count(NC_W'(0));
		q = {mk_item(OP_RUN, 15, 15, 16'hFFFF)};
		send_batch(q);
		drain();

		// ties on column and on row, a diagonal entry, entries beyond the graph
		set_node_count(NC_W'(4));
		q = {mk_item(OP_WRITE, 0, 1, 5), mk_item(OP_WRITE, 2, 0, 5),
			mk_item(OP_WRITE, 1, 2, 5), mk_item(OP_WRITE, 2, 3, 16'hFFFF),
			mk_item(OP_WRITE, 1, 3, 16'hFFFF), mk_item(OP_WRITE, 3, 3, 1),
			mk_item(OP_WRITE, 15, 0, 1), mk_item(OP_WRITE, 15, 15, 16'hFFFF),
			mk_item(OP_RUN, 0, 0, 0),
			mk_item(OP_WRITE, 3, 1, 0), mk_item(OP_WRITE, 2, 3, 0),
			mk_item(OP_RUN, 7, 9, 16'h1234)};
		send_batch(q);
		drain();
		set_node_count(NC_W'(2));
		q = {mk_item(OP_RUN, 0, 0, 0)};
		send_batch(q);
		drain();

		phase_cfg = '{NC_W'(5), NC_W'(16), NC_W'(2), NC_W'(31), NC_W'(6),
			NC_W'($urandom_range(3, 12))};
		for (phase = 0; phase < 6; phase++) begin
			case (phase / 2)
				0: begin
					send_idle_pct = 9;
					recv_idle_pct = 81;
				end
				1: begin
					send_idle_pct = 81;
					recv_idle_pct = 9;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			set_node_count(phase_cfg[phase]);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				build_scenario(q);
				// stall the result side while runs and writes keep arriving
				if (phase == 4 && sent == 0)
					hold_req++;
				send_batch(q);
				sent += q.size();
			end
			drain();
		end

		repeat (TAIL_CYCLES) @(negedge clk);
		$display("Covered %0d input transactions and %0d runs over node_count 0..31:",
			sb.accepted, sb.runs);
		$display("  %0d tree edges, %0d empty trees, %0d disconnected graphs checked",
			sb.edges, sb.empties, sb.disconnects);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS prim_minimum_spanning_tree");
		else
			$display("FAIL prim_minimum_spanning_tree");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/pmst_pkg.sv
rtl/pmst_ram.sv
rtl/pmst_ctrl.sv
rtl/pmst_dp.sv
rtl/prim_minimum_spanning_tree.sv
tb/prim_minimum_spanning_tree_tb.sv
